FILE: rtl/look_at_view_matrix_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the look-at view matrix block
// Checks sampled on the rising clock edge, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication.
`define LLV_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("look_at_view_matrix check failed");

// Next-cycle implication.
`define LLV_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("look_at_view_matrix check failed");

`endif

FILE: rtl/llv_pkg.sv
// ----------------------------------------------------------------------------
// llv_pkg
// Shared types, constants and rounding helpers of the look-at view matrix.
// ----------------------------------------------------------------------------
package llv_pkg;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic signed [37:0] ONE30 = 38'sd1073741824;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [31:0] offset;
        logic               degenerate;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic     avail;
        logic     hint;
        t_in_word word;
    } t_q_head;

    typedef struct packed {
        logic               start;
        logic signed [33:0] c_x;
        logic signed [33:0] c_y;
        logic signed [33:0] c_z;
    } t_norm_req;

    typedef struct packed {
        logic               done;
        logic               zero;
        logic signed [31:0] o_x;
        logic signed [31:0] o_y;
        logic signed [31:0] o_z;
    } t_norm_rsp;

    // Divide by 2^30, rounding to nearest with ties away from zero.
    function automatic logic signed [37:0] rnd30(input logic signed [66:0] x);
        logic [66:0] m;
        logic [66:0] r;
        m = x[66] ? 67'(-x) : 67'(x);
        r = (m + 67'd536870912) >> 30;
        return x[66] ? -$signed(r[37:0]) : $signed(r[37:0]);
    endfunction

    function automatic logic signed [31:0] clamp30(input logic signed [37:0] x);
        if (x > ONE30) begin
            return 32'sh40000000;
        end else if (x < -ONE30) begin
            return -32'sh40000000;
        end
        return x[31:0];
    endfunction

    // Negate and saturate to 32 bits.
    function automatic logic signed [31:0] sat32neg(input logic signed [37:0] x);
        logic signed [38:0] nx;
        nx = -{x[37], x};
        if (nx > 39'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (nx < -39'sd2147483648) begin
            return 32'sh80000000;
        end
        return nx[31:0];
    endfunction

endpackage

FILE: rtl/llv_front.sv
// ----------------------------------------------------------------------------
// llv_front
// Accepts input words, flags trivially degenerate ones and queues them.
// ----------------------------------------------------------------------------
module llv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  llv_pkg::t_in_word i_word,
    input  logic              i_pop,
    output logic              o_busy,
    output llv_pkg::t_q_head  o_head
);

    llv_pkg::t_in_word         r_mem [llv_pkg::QDEPTH];
    logic [llv_pkg::QDEPTH-1:0] r_hint;
    logic [llv_pkg::QAW-1:0]    r_wp;
    logic [llv_pkg::QAW-1:0]    r_rp;
    logic [llv_pkg::QAW:0]      r_cnt;
    logic                       accept;
    logic                       hint;

    assign o_busy = (r_cnt == (llv_pkg::QAW+1)'(llv_pkg::QDEPTH));
    assign accept = i_start && !o_busy;
    assign hint   = (i_word.look_x == 32'sd0 && i_word.look_y == 32'sd0 &&
                     i_word.look_z == 32'sd0) ||
                    (i_word.up_x == 32'sd0 && i_word.up_y == 32'sd0 &&
                     i_word.up_z == 32'sd0);

    assign o_head.avail = (r_cnt != '0);
    assign o_head.hint  = r_hint[r_rp];
    assign o_head.word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wp]  <= i_word;
            r_hint[r_wp] <= hint;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (accept && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!accept && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/llv_norm.sv
// ----------------------------------------------------------------------------
// llv_norm
// Normalizes a three-component vector to Q2.30 with an iterative square
// root and a shared restoring divider.
// ----------------------------------------------------------------------------
module llv_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  llv_pkg::t_norm_req i_req,
    output llv_pkg::t_norm_rsp o_rsp
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SHIFT = 7'b0000010,
        S_SQ    = 7'b0000100,
        S_SQRT  = 7'b0001000,
        S_DLOAD = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_nstate;

    t_nstate            r_state;
    logic [33:0]        r_m [3];
    logic [2:0]         r_neg;
    logic [4:0]         r_cnt;
    logic [1:0]         r_idx;
    logic [61:0]        r_prod;
    logic [63:0]        r_sum;
    logic [63:0]        r_x;
    logic [63:0]        r_root;
    logic [63:0]        r_bit;
    logic [31:0]        r_len;
    logic [31:0]        r_rem;
    logic [31:0]        r_nsr;
    logic [31:0]        r_q;
    logic signed [31:0] r_o [3];
    logic               r_zero;

    logic signed [33:0] c_in [3];
    logic [33:0]        mx;
    logic [1:0]         sq_sel;
    logic [64:0]        root_try;
    logic               root_ge;
    logic [63:0]        n_root;
    logic [61:0]        num;
    logic [32:0]        sh;
    logic               dge;
    logic [32:0]        dsub;
    logic [31:0]        q_fin;
    logic [31:0]        q_clamp;

    assign c_in[0] = i_req.c_x;
    assign c_in[1] = i_req.c_y;
    assign c_in[2] = i_req.c_z;

    always_comb begin
        mx = r_m[0];
        if (r_m[1] > mx) begin
            mx = r_m[1];
        end
        if (r_m[2] > mx) begin
            mx = r_m[2];
        end
    end

    assign sq_sel   = (r_cnt[1:0] == 2'd3) ? 2'd0 : r_cnt[1:0];
    assign root_try = {1'b0, r_root} + {1'b0, r_bit};
    assign root_ge  = ({1'b0, r_x} >= root_try);
    assign n_root   = root_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
    assign num      = {1'b0, r_m[r_idx][30:0], 30'd0} + {31'd0, r_len[31:1]};
    assign sh       = {r_rem, r_nsr[31]};
    assign dge      = (sh >= {1'b0, r_len});
    assign dsub     = sh - {1'b0, r_len};
    assign q_fin    = {r_q[30:0], dge};
    assign q_clamp  = (q_fin > 32'h40000000) ? 32'h40000000 : q_fin;

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.zero = r_zero;
    assign o_rsp.o_x  = r_o[0];
    assign o_rsp.o_y  = r_o[1];
    assign o_rsp.o_z  = r_o[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_zero  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i]   <= c_in[i][33] ? 34'(-c_in[i]) : 34'(c_in[i]);
                            r_neg[i] <= c_in[i][33];
                        end
                        r_zero  <= 1'b0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (mx == 34'd0) begin
                        r_zero  <= 1'b1;
                        r_o[0]  <= '0;
                        r_o[1]  <= '0;
                        r_o[2]  <= '0;
                        r_state <= S_DONE;
                    end else if (mx >= 34'h080000000) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] >> 1;
                        end
                    end else if (mx < 34'h040000000) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] << 1;
                        end
                    end else begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= 62'(r_m[sq_sel][30:0]) * 62'(r_m[sq_sel][30:0]);
                    if (r_cnt != 5'd0) begin
                        r_sum <= r_sum + {2'd0, r_prod};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd3) begin
                        r_x     <= r_sum + {2'd0, r_prod};
                        r_root  <= '0;
                        r_bit   <= 64'h4000000000000000;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (root_ge) begin
                        r_x <= r_x - root_try[63:0];
                    end
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_len   <= n_root[31:0];
                        r_idx   <= '0;
                        r_state <= S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    r_rem   <= {2'd0, num[61:32]};
                    r_nsr   <= num[31:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= dge ? dsub[31:0] : sh[31:0];
                    r_nsr <= r_nsr << 1;
                    r_q   <= q_fin;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_o[r_idx] <= r_neg[r_idx] ? -$signed(q_clamp) : $signed(q_clamp);
                        r_idx      <= r_idx + 2'd1;
                        r_state    <= (r_idx == 2'd2) ? S_DONE : S_DLOAD;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/llv_back.sv
// ----------------------------------------------------------------------------
// llv_back
// Sequences one queued word through the degeneracy test, the three
// normalizations, projection, cross product and offsets, then emits rows.
// ----------------------------------------------------------------------------
module llv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  llv_pkg::t_q_head   i_head,
    output logic               o_pop,
    output llv_pkg::t_norm_req o_nreq,
    input  llv_pkg::t_norm_rsp i_nrsp,
    output logic               o_valid,
    output llv_pkg::t_out_word o_word
);

    typedef enum logic [9:0] {
        B_IDLE  = 10'b0000000001,
        B_CROSS = 10'b0000000010,
        B_NW    = 10'b0000000100,
        B_NU    = 10'b0000001000,
        B_DOT   = 10'b0000010000,
        B_PROJ  = 10'b0000100000,
        B_NV    = 10'b0001000000,
        B_CRU   = 10'b0010000000,
        B_OFF   = 10'b0100000000,
        B_OUT   = 10'b1000000000
    } t_bstate;

    t_bstate            r_state;
    logic [3:0]         r_k;
    logic signed [31:0] r_p  [3];
    logic signed [31:0] r_lk [3];
    logic signed [31:0] r_up [3];
    logic signed [31:0] r_w  [3];
    logic signed [31:0] r_uh [3];
    logic signed [31:0] r_v  [3];
    logic signed [31:0] r_u  [3];
    logic signed [33:0] r_t  [3];
    logic signed [31:0] r_off [3];
    logic signed [32:0] r_d;
    logic               r_degen;
    logic               r_nz;
    logic               r_nstart;
    logic signed [65:0] r_prod;
    logic               r_pv;
    logic               r_psub;
    logic               r_pfirst;
    logic               r_plast;
    logic [1:0]         r_pgrp;
    logic signed [66:0] r_acc;
    logic               r_valid;
    llv_pkg::t_out_word r_out;

    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic               op_sub;
    logic               op_first;
    logic               op_last;
    logic [1:0]         op_grp;
    logic               issue;
    logic [1:0]         orow;
    logic [1:0]         ocol;
    logic signed [31:0] ovec;
    logic signed [66:0] prod_ext;
    logic signed [66:0] acc_n;
    logic signed [37:0] rnd;
    logic signed [37:0] tval;
    logic signed [31:0] nw_o [3];

    function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
        return {x[31], x};
    endfunction

    assign nw_o[0] = i_nrsp.o_x;
    assign nw_o[1] = i_nrsp.o_y;
    assign nw_o[2] = i_nrsp.o_z;

    always_comb begin
        orow = 2'd0;
        ocol = 2'd0;
        if (r_k < 4'd3) begin
            ocol = r_k[1:0];
        end else if (r_k < 4'd6) begin
            orow = 2'd1;
            ocol = 2'(r_k - 4'd3);
        end else begin
            orow = 2'd2;
            ocol = 2'(r_k - 4'd6);
        end
        case (orow)
            2'd0:    ovec = r_u[ocol];
            2'd1:    ovec = r_v[ocol];
            default: ovec = r_w[ocol];
        endcase
    end

    always_comb begin
        op_a     = '0;
        op_b     = '0;
        op_sub   = 1'b0;
        op_first = 1'b0;
        op_last  = 1'b0;
        op_grp   = 2'd0;
        issue    = 1'b0;
        case (r_state)
            B_CROSS, B_CRU: begin
                issue    = (r_k < 4'd6);
                op_first = !r_k[0];
                op_last  = r_k[0];
                op_sub   = r_k[0];
                case (r_k)
                    4'd0: begin
                        op_a = (r_state == B_CROSS) ? sx33(r_lk[1]) : sx33(r_v[1]);
                        op_b = (r_state == B_CROSS) ? sx33(r_up[2]) : sx33(r_w[2]);
                    end
                    4'd1: begin
                        op_a = (r_state == B_CROSS) ? sx33(r_lk[2]) : sx33(r_v[2]);
                        op_b = (r_state == B_CROSS) ? sx33(r_up[1]) : sx33(r_w[1]);
                    end
                    4'd2: begin
                        op_a   = (r_state == B_CROSS) ? sx33(r_lk[2]) : sx33(r_v[2]);
                        op_b   = (r_state == B_CROSS) ? sx33(r_up[0]) : sx33(r_w[0]);
                        op_grp = 2'd1;
                    end
                    4'd3: begin
                        op_a   = (r_state == B_CROSS) ? sx33(r_lk[0]) : sx33(r_v[0]);
                        op_b   = (r_state == B_CROSS) ? sx33(r_up[2]) : sx33(r_w[2]);
                        op_grp = 2'd1;
                    end
                    4'd4: begin
                        op_a   = (r_state == B_CROSS) ? sx33(r_lk[0]) : sx33(r_v[0]);
                        op_b   = (r_state == B_CROSS) ? sx33(r_up[1]) : sx33(r_w[1]);
                        op_grp = 2'd2;
                    end
                    4'd5: begin
                        op_a   = (r_state == B_CROSS) ? sx33(r_lk[1]) : sx33(r_v[1]);
                        op_b   = (r_state == B_CROSS) ? sx33(r_up[0]) : sx33(r_w[0]);
                        op_grp = 2'd2;
                    end
                    default: begin
                        op_a = '0;
                    end
                endcase
            end
            B_DOT: begin
                issue    = (r_k < 4'd3);
                op_a     = sx33(r_uh[ocol]);
                op_b     = sx33(r_w[ocol]);
                op_first = (r_k == 4'd0);
                op_last  = (r_k == 4'd2);
            end
            B_PROJ: begin
                issue    = (r_k < 4'd3);
                op_a     = r_d;
                op_b     = sx33(r_w[ocol]);
                op_first = 1'b1;
                op_last  = 1'b1;
                op_grp   = ocol;
            end
            B_OFF: begin
                issue    = (r_k < 4'd9);
                op_a     = sx33(ovec);
                op_b     = sx33(r_p[ocol]);
                op_first = (ocol == 2'd0);
                op_last  = (ocol == 2'd2);
                op_grp   = orow;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign prod_ext = {r_prod[65], r_prod};
    assign acc_n    = (r_pfirst ? 67'sd0 : r_acc) + (r_psub ? -prod_ext : prod_ext);
    assign rnd      = llv_pkg::rnd30(acc_n);
    assign tval     = {{6{r_uh[r_pgrp][31]}}, r_uh[r_pgrp]} - rnd;

    assign o_pop   = (r_state == B_IDLE) && i_head.avail;
    assign o_valid = r_valid;
    assign o_word  = r_out;

    always_comb begin
        o_nreq       = '0;
        o_nreq.start = r_nstart;
        case (r_state)
            B_NW: begin
                o_nreq.c_x = -{{2{r_lk[0][31]}}, r_lk[0]};
                o_nreq.c_y = -{{2{r_lk[1][31]}}, r_lk[1]};
                o_nreq.c_z = -{{2{r_lk[2][31]}}, r_lk[2]};
            end
            B_NU: begin
                o_nreq.c_x = {{2{r_up[0][31]}}, r_up[0]};
                o_nreq.c_y = {{2{r_up[1][31]}}, r_up[1]};
                o_nreq.c_z = {{2{r_up[2][31]}}, r_up[2]};
            end
            B_NV: begin
                o_nreq.c_x = r_t[0];
                o_nreq.c_y = r_t[1];
                o_nreq.c_z = r_t[2];
            end
            default: begin
                o_nreq.c_x = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= op_a * op_b;
        r_psub   <= op_sub;
        r_pfirst <= op_first;
        r_plast  <= op_last;
        r_pgrp   <= op_grp;
        if (r_pv) begin
            r_acc <= acc_n;
        end
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_k      <= '0;
            r_pv     <= 1'b0;
            r_nstart <= 1'b0;
            r_valid  <= 1'b0;
            r_degen  <= 1'b0;
            r_nz     <= 1'b0;
        end else begin
            r_pv     <= issue;
            r_nstart <= 1'b0;
            r_valid  <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_head.avail) begin
                        r_p[0]  <= i_head.word.pos_x;
                        r_p[1]  <= i_head.word.pos_y;
                        r_p[2]  <= i_head.word.pos_z;
                        r_lk[0] <= i_head.word.look_x;
                        r_lk[1] <= i_head.word.look_y;
                        r_lk[2] <= i_head.word.look_z;
                        r_up[0] <= i_head.word.up_x;
                        r_up[1] <= i_head.word.up_y;
                        r_up[2] <= i_head.word.up_z;
                        r_k     <= '0;
                        r_nz    <= 1'b0;
                        r_degen <= i_head.hint;
                        r_state <= i_head.hint ? B_OUT : B_CROSS;
                    end
                end
                B_CROSS: begin
                    if (r_pv && r_plast && acc_n != 67'sd0) begin
                        r_nz <= 1'b1;
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd6) begin
                        r_k <= '0;
                        if (!(r_nz || acc_n != 67'sd0)) begin
                            r_degen <= 1'b1;
                            r_state <= B_OUT;
                        end else begin
                            r_nstart <= 1'b1;
                            r_state  <= B_NW;
                        end
                    end
                end
                B_NW: begin
                    if (i_nrsp.done) begin
                        r_w      <= nw_o;
                        r_nstart <= 1'b1;
                        r_state  <= B_NU;
                    end
                end
                B_NU: begin
                    if (i_nrsp.done) begin
                        r_uh    <= nw_o;
                        r_k     <= '0;
                        r_state <= B_DOT;
                    end
                end
                B_DOT: begin
                    if (r_pv && r_plast) begin
                        r_d <= rnd[32:0];
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd3) begin
                        r_k     <= '0;
                        r_state <= B_PROJ;
                    end
                end
                B_PROJ: begin
                    if (r_pv && r_plast) begin
                        r_t[r_pgrp] <= tval[33:0];
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd3) begin
                        r_k      <= '0;
                        r_nstart <= 1'b1;
                        r_state  <= B_NV;
                    end
                end
                B_NV: begin
                    if (i_nrsp.done) begin
                        r_k <= '0;
                        if (i_nrsp.zero) begin
                            r_degen <= 1'b1;
                            r_state <= B_OUT;
                        end else begin
                            r_v     <= nw_o;
                            r_state <= B_CRU;
                        end
                    end
                end
                B_CRU: begin
                    if (r_pv && r_plast) begin
                        r_u[r_pgrp] <= llv_pkg::clamp30(rnd);
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd6) begin
                        r_k     <= '0;
                        r_state <= B_OFF;
                    end
                end
                B_OFF: begin
                    if (r_pv && r_plast) begin
                        r_off[r_pgrp] <= llv_pkg::sat32neg(rnd);
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd9) begin
                        r_k     <= '0;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    r_valid          <= 1'b1;
                    r_out.row_index  <= r_k[1:0];
                    r_out.degenerate <= r_degen;
                    r_out.last       <= (r_k == 4'd2);
                    if (r_degen) begin
                        r_out.axis_x <= '0;
                        r_out.axis_y <= '0;
                        r_out.axis_z <= '0;
                        r_out.offset <= '0;
                    end else begin
                        r_out.offset <= r_off[ocol];
                        case (r_k)
                            4'd0: begin
                                r_out.axis_x <= r_u[0];
                                r_out.axis_y <= r_u[1];
                                r_out.axis_z <= r_u[2];
                            end
                            4'd1: begin
                                r_out.axis_x <= r_v[0];
                                r_out.axis_y <= r_v[1];
                                r_out.axis_z <= r_v[2];
                            end
                            default: begin
                                r_out.axis_x <= r_w[0];
                                r_out.axis_y <= r_w[1];
                                r_out.axis_z <= r_w[2];
                            end
                        endcase
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd2) begin
                        r_k     <= '0;
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/look_at_view_matrix_top.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_top
// Builds the three rows of a look-at view matrix from position, look and up.
// ----------------------------------------------------------------------------
// The time per word is set by the shared normalize unit: a 32-step square
// root and three 32-step divisions for each of w, up and v. A zero look or an
// up parallel to look skips the normalizations. The three rows leave on
// consecutive cycles. A two-word queue takes new words while one is at work.
// Synchronous reset empties the queue and idles both sequencers.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_top_assert.svh"

module look_at_view_matrix_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  llv_pkg::t_in_word  i_word,
    output logic               busy,
    output logic               o_valid,
    output llv_pkg::t_out_word o_word
);

    llv_pkg::t_q_head   head;
    logic               pop;
    llv_pkg::t_norm_req nreq;
    llv_pkg::t_norm_rsp nrsp;

    llv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_word  (i_word),
        .i_pop   (pop),
        .o_busy  (busy),
        .o_head  (head)
    );

    llv_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (nreq),
        .o_rsp   (nrsp)
    );

    llv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_nreq  (nreq),
        .i_nrsp  (nrsp),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    `LLV_CHK_NOW(a_last_row, o_valid, o_word.last == (o_word.row_index == 2'd2))
    `LLV_CHK_NEXT(a_row_order, o_valid && !o_word.last, o_valid && (o_word.row_index == $past(o_word.row_index) + 2'd1))
    `LLV_CHK_NOW(a_degen_zero, o_valid && o_word.degenerate, o_word.axis_x == 32'sd0 && o_word.offset == 32'sd0)

endmodule

FILE: tb/look_at_view_matrix_checker.sv
// ----------------------------------------------------------------------------
// Look-at view matrix checker
// Watches accepted input words and result rows, predicts the three rows of
// each word in fixed point and compares every row field by field in order.
// ----------------------------------------------------------------------------
module look_at_view_matrix_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  llv_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  llv_pkg::t_out_word i_out_word,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_rows_seen,
    output int                 o_degen_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNIT = 64'sd1073741824;

    typedef logic signed [63:0] t_s64;
    typedef t_s64 t_vec[3];

    llv_pkg::t_out_word rows_due[$];

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_s64 round_q30(input t_s64 x);
        logic [63:0] m;
        m = x < 0 ? -x : x;
        m = (m + (64'd1 << 29)) >> 30;
        return x < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_s64 limit_unit(input t_s64 x);
        if (x > UNIT) return UNIT;
        if (x < -UNIT) return -UNIT;
        return x;
    endfunction

    function automatic bit unit_vec(input t_vec c, output t_vec o);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] > mx) mx = m[i];
            o[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + len / 2) / len;
            if (q > (64'd1 << 30)) q = 64'd1 << 30;
            o[i] = c[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1;
    endfunction

    function automatic llv_pkg::t_out_word view_row(input int k, input t_vec a,
                                                    input t_vec p, input bit dg);
        llv_pkg::t_out_word r;
        t_s64 off;
        off = 0;
        if (!dg) begin
            off = -round_q30(a[0] * p[0] + a[1] * p[1] + a[2] * p[2]);
            if (off > 64'sd2147483647) off = 64'sd2147483647;
            if (off < -64'sd2147483648) off = -64'sd2147483648;
        end
        r.row_index = 2'(k);
        r.axis_x = dg ? 32'sd0 : a[0][31:0];
        r.axis_y = dg ? 32'sd0 : a[1][31:0];
        r.axis_z = dg ? 32'sd0 : a[2][31:0];
        r.offset = off[31:0];
        r.degenerate = dg;
        r.last = (k == 2);
        return r;
    endfunction

    task automatic predict_view_rows(input llv_pkg::t_in_word x);
        t_vec p, lk, up, nl, w, uh, t, v, u;
        t_s64 d;
        bit dg;
        p = '{x.pos_x, x.pos_y, x.pos_z};
        lk = '{x.look_x, x.look_y, x.look_z};
        up = '{x.up_x, x.up_y, x.up_z};
        for (int i = 0; i < 3; i++) nl[i] = -lk[i];
        dg = (lk[1] * up[2] == lk[2] * up[1]) && (lk[2] * up[0] == lk[0] * up[2])
             && (lk[0] * up[1] == lk[1] * up[0]);
        if (!unit_vec(nl, w)) dg = 1;
        if (!dg && !unit_vec(up, uh)) dg = 1;
        if (!dg) begin
            d = round_q30(uh[0] * w[0] + uh[1] * w[1] + uh[2] * w[2]);
            for (int i = 0; i < 3; i++) t[i] = uh[i] - round_q30(d * w[i]);
            if (!unit_vec(t, v)) dg = 1;
        end
        if (!dg) begin
            u[0] = limit_unit(round_q30(v[1] * w[2] - v[2] * w[1]));
            u[1] = limit_unit(round_q30(v[2] * w[0] - v[0] * w[2]));
            u[2] = limit_unit(round_q30(v[0] * w[1] - v[1] * w[0]));
        end
        rows_due.push_back(view_row(0, u, p, dg));
        rows_due.push_back(view_row(1, v, p, dg));
        rows_due.push_back(view_row(2, w, p, dg));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors <= 0;
            o_rows_seen <= 0;
            o_degen_seen <= 0;
            rows_due.delete();
        end else begin
            if (i_out_valid) begin
                o_rows_seen <= o_rows_seen + 1;
                if (i_out_word.degenerate) o_degen_seen <= o_degen_seen + 1;
                if (rows_due.size() == 0) begin
                    $display("%t unexpected row: actual %p", $realtime, i_out_word);
                    o_errors <= o_errors + 1;
                end else begin
                    if (i_out_word !== rows_due[0]) begin
                        $display("%t row mismatch: expected %p actual %p", $realtime,
                                 rows_due[0], i_out_word);
                        o_errors <= o_errors + 1;
                    end
                    void'(rows_due.pop_front());
                end
            end
            if (i_start && !i_busy) predict_view_rows(i_in_word);
        end
    end

    assign o_pending = rows_due.size();
endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Sends directed and random camera words in bursts and reports the verdict
// from the checker's failure and pending-row counts.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_LIMIT = 20000;
    localparam int RANDOM_WORDS = 290;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    llv_pkg::t_in_word  i_word;
    logic               busy;
    logic               o_valid;
    llv_pkg::t_out_word o_word;
    int                 errors, pending, rows_seen, degen_seen;
    int                 sent;
    int                 idle_cycles;

    look_at_view_matrix_top dut (.*);

    look_at_view_matrix_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_in_word(i_word), .i_out_valid(o_valid), .i_out_word(o_word),
        .o_errors(errors), .o_pending(pending), .o_rows_seen(rows_seen),
        .o_degen_seen(degen_seen)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'($signed($urandom_range(0, 40)) - 20);
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input llv_pkg::t_in_word x);
        i_word <= x;
        start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_parts(input logic [31:0] px, py, pz, lx, ly, lz, ux, uy, uz);
        llv_pkg::t_in_word x;
        x = '{px, py, pz, lx, ly, lz, ux, uy, uz};
        send_word(x);
    endtask

    task automatic idle_gap();
        start <= 0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic random_word();
        llv_pkg::t_in_word x;
        int k;
        x = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        k = $urandom_range(0, 9);
        if (k == 0) begin
            x.up_x = x.look_x * 2;
            x.up_y = x.look_y * 2;
            x.up_z = x.look_z * 2;
        end else if (k == 1) begin
            x.up_x = x.look_x;
            x.up_y = x.look_y;
            x.up_z = x.look_z + 1;
        end else if (k == 2) begin
            x.look_x = 0;
            x.look_y = 0;
            x.look_z = 0;
        end
        send_word(x);
    endtask

    initial begin
        logic [31:0] one;
        int burst;
        one = 32'h00010000;
        i_rst_n = 0;
        start = 0;
        i_word = '0;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_parts(0, 0, 0, 0, 0, -one, 0, one, 0);
        send_parts(one, 2 * one, 3 * one, 0, 0, -one, 0, one, 0);
        send_parts(0, 0, 0, 0, 0, 0, 0, one, 0);
        send_parts(0, 0, 0, 0, one, 0, 0, one, 0);
        send_parts(0, 0, 0, one, 0, 0, 0, 0, 0);
        send_parts(0, 0, 0, 0, 0, one, 0, -3 * one, 0);
        send_parts(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0, 0, 0, 1, 0);
        send_parts(32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
        send_parts(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 1,
                   32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_parts(0, 0, 0, 32'h40000000, 0, 0, 32'h40000000, 1, 0);
        send_parts(one, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 0, 0);
        send_parts(32'hffffffff, 32'hffffffff, 32'hffffffff,
                   32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0);
        send_parts(32'h55555555, 32'haaaaaaaa, 32'h12345678, 3, 4, 5, 32'h7fffffff, 0, 1);
        start <= 0;
        while (pending != 0) @(posedge i_clk);
        for (int n = 0; n < RANDOM_WORDS; ) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && n < RANDOM_WORDS; b++, n++) random_word();
            if (n == RANDOM_WORDS / 2) begin
                start <= 0;
                while (pending != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                idle_gap();
            end
        end
        start <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        $display("Sent %0d camera words, checked %0d rows, %0d of them degenerate.",
                 sent, rows_seen, degen_seen);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
